// ===== design/quadrotor_observer_state_feedback_macros.svh =====
// Assertion macros for the quadrotor observer and state-feedback block.
// Synthesis builds see empty bodies.
`ifndef QUADROTOR_OBSERVER_STATE_FEEDBACK_MACROS_SVH
`define QUADROTOR_OBSERVER_STATE_FEEDBACK_MACROS_SVH
`ifndef SYNTHESIS
`define QOSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qosf: same-cycle check failed");
`define QOSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qosf: next-cycle check failed");
`else
`define QOSF_ASSERT_IMP(lbl, ante, cons)
`define QOSF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/qosf_pkg.sv =====
`default_nettype none

package qosf_pkg;

  // Fixed-point format of the internal state.
  localparam int FRAC_BITS = 32;
  localparam int IN_SHIFT  = FRAC_BITS - 16;
  localparam int K_SHL     = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int K_SHR     = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  // Register file slots.
  localparam int RF_DEPTH = 30;
  typedef logic [4:0] rf_idx_t;

  localparam rf_idx_t R_S0  = 5'd0;
  localparam rf_idx_t R_S1  = 5'd1;
  localparam rf_idx_t R_S2  = 5'd2;
  localparam rf_idx_t R_S3  = 5'd3;
  localparam rf_idx_t R_S4  = 5'd4;
  localparam rf_idx_t R_S5  = 5'd5;
  localparam rf_idx_t R_S6  = 5'd6;
  localparam rf_idx_t R_S7  = 5'd7;
  localparam rf_idx_t R_S8  = 5'd8;
  localparam rf_idx_t R_P0  = 5'd9;
  localparam rf_idx_t R_P1  = 5'd10;
  localparam rf_idx_t R_GX  = 5'd11;
  localparam rf_idx_t R_GY  = 5'd12;
  localparam rf_idx_t R_GZ  = 5'd13;
  localparam rf_idx_t R_AZ  = 5'd14;
  localparam rf_idx_t R_FX  = 5'd15;
  localparam rf_idx_t R_FY  = 5'd16;
  localparam rf_idx_t R_RNG = 5'd17;
  localparam rf_idx_t R_DX  = 5'd18;
  localparam rf_idx_t R_DY  = 5'd19;
  localparam rf_idx_t R_DZ  = 5'd20;
  localparam rf_idx_t R_RR  = 5'd21;
  localparam rf_idx_t R_PR  = 5'd22;
  localparam rf_idx_t R_YR  = 5'd23;
  localparam rf_idx_t R_TQR = 5'd24;
  localparam rf_idx_t R_TQP = 5'd25;
  localparam rf_idx_t R_EX  = 5'd26;
  localparam rf_idx_t R_EY  = 5'd27;
  localparam rf_idx_t R_EZ  = 5'd28;
  localparam rf_idx_t R_T   = 5'd29;
  // Slots reused once their input has been consumed.
  localparam rf_idx_t R_AX  = R_GX;
  localparam rf_idx_t R_AY  = R_GY;
  localparam rf_idx_t R_BZ  = R_GZ;
  localparam rf_idx_t R_CF  = R_FX;

  // Q32.32 constants, rounded to nearest.
  localparam logic [63:0] QK_DEG2RAD =
    ((64'd314159265 << 32) + 64'd18000000000 / 64'd2) / 64'd18000000000;
  localparam logic [63:0] QK_G     = ((64'd981 << 32) + 64'd100 / 64'd2) / 64'd100;
  localparam logic [63:0] QK_DT    = ((64'd2 << 32) + 64'd1000 / 64'd2) / 64'd1000;
  localparam logic [63:0] QK_JX_DT = ((64'd84 << 32) + 64'd10000 / 64'd2) / 64'd10000;
  localparam logic [63:0] QK_JY_DT = ((64'd845 << 32) + 64'd100000 / 64'd2) / 64'd100000;
  localparam logic [63:0] QK_FLOW  =
    ((64'd409255568 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_FLOW_Z =
    ((64'd818511136 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_L_RANGE_Z =
    ((64'd21781746 << 32) + 64'd1000000 / 64'd2) / 64'd1000000;
  localparam logic [63:0] QK_L_FLOW_PITCH =
    ((64'd1497 << 32) + 64'd1000000 / 64'd2) / 64'd1000000;
  localparam logic [63:0] QK_L_FLOW_ROLL =
    ((64'd1652 << 32) + 64'd1000000 / 64'd2) / 64'd1000000;
  localparam logic [63:0] QK_L_FLOW_VX =
    ((64'd61758 << 32) + 64'd1000000 / 64'd2) / 64'd1000000;
  localparam logic [63:0] QK_L_FLOW_VY =
    ((64'd64906 << 32) + 64'd1000000 / 64'd2) / 64'd1000000;
  localparam logic [63:0] QK_L_RANGE_VZ =
    ((64'd98333333 << 32) + 64'd1000000 / 64'd2) / 64'd1000000;
  localparam logic [63:0] QK_G_POS_XY =
    ((64'd657196 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_ROLL_ANG =
    ((64'd1089931 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_ROLL_VEL =
    ((64'd394655 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_ROLL_RATE =
    ((64'd149955 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_ROLL_TQ =
    ((64'd274590184 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_PITCH_ANG =
    ((64'd1090571 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_PITCH_VEL =
    ((64'd394763 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_PITCH_RATE =
    ((64'd150133 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_PITCH_TQ =
    ((64'd273765352 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_YAW_ANG =
    ((64'd96575 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_YAW_RATE =
    ((64'd38228 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_Z_POS =
    ((64'd34995563 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_Z_VEL =
    ((64'd16359250 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_G_Z_OFS =
    ((64'd33648300 << 32) + 64'd100000000 / 64'd2) / 64'd100000000;
  localparam logic [63:0] QK_M_TILT  = ((64'd29377203 << 32) + 64'd10 / 64'd2) / 64'd10;
  localparam logic [63:0] QK_M_YAW   = ((64'd346260388 << 32) + 64'd10 / 64'd2) / 64'd10;
  localparam logic [63:0] QK_M_THRUST = ((64'd1351351 << 32) + 64'd10 / 64'd2) / 64'd10;

  typedef enum logic [4:0] {
    KC_DEG2RAD, KC_G, KC_DT, KC_JX_DT, KC_JY_DT, KC_FLOW, KC_FLOW_Z,
    KC_L_RANGE_Z, KC_L_FLOW_PITCH, KC_L_FLOW_ROLL, KC_L_FLOW_VX, KC_L_FLOW_VY,
    KC_L_RANGE_VZ, KC_G_POS_XY, KC_G_ROLL_ANG, KC_G_ROLL_VEL, KC_G_ROLL_RATE,
    KC_G_ROLL_TQ, KC_G_PITCH_ANG, KC_G_PITCH_VEL, KC_G_PITCH_RATE, KC_G_PITCH_TQ,
    KC_G_YAW_ANG, KC_G_YAW_RATE, KC_G_Z_POS, KC_G_Z_VEL, KC_G_Z_OFS,
    KC_M_TILT, KC_M_YAW, KC_M_THRUST
  } kc_e;

  typedef enum logic [3:0] {
    OP_LD, OP_LDK, OP_ADD, OP_SUB, OP_RSUB, OP_NEG, OP_MUL, OP_ST, OP_MOT, OP_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] arg;
  } instr_t;

  function automatic logic [63:0] kconst(kc_e k);
    logic [63:0] v;
    unique case (k)
      KC_DEG2RAD:      v = QK_DEG2RAD;
      KC_G:            v = QK_G;
      KC_DT:           v = QK_DT;
      KC_JX_DT:        v = QK_JX_DT;
      KC_JY_DT:        v = QK_JY_DT;
      KC_FLOW:         v = QK_FLOW;
      KC_FLOW_Z:       v = QK_FLOW_Z;
      KC_L_RANGE_Z:    v = QK_L_RANGE_Z;
      KC_L_FLOW_PITCH: v = QK_L_FLOW_PITCH;
      KC_L_FLOW_ROLL:  v = QK_L_FLOW_ROLL;
      KC_L_FLOW_VX:    v = QK_L_FLOW_VX;
      KC_L_FLOW_VY:    v = QK_L_FLOW_VY;
      KC_L_RANGE_VZ:   v = QK_L_RANGE_VZ;
      KC_G_POS_XY:     v = QK_G_POS_XY;
      KC_G_ROLL_ANG:   v = QK_G_ROLL_ANG;
      KC_G_ROLL_VEL:   v = QK_G_ROLL_VEL;
      KC_G_ROLL_RATE:  v = QK_G_ROLL_RATE;
      KC_G_ROLL_TQ:    v = QK_G_ROLL_TQ;
      KC_G_PITCH_ANG:  v = QK_G_PITCH_ANG;
      KC_G_PITCH_VEL:  v = QK_G_PITCH_VEL;
      KC_G_PITCH_RATE: v = QK_G_PITCH_RATE;
      KC_G_PITCH_TQ:   v = QK_G_PITCH_TQ;
      KC_G_YAW_ANG:    v = QK_G_YAW_ANG;
      KC_G_YAW_RATE:   v = QK_G_YAW_RATE;
      KC_G_Z_POS:      v = QK_G_Z_POS;
      KC_G_Z_VEL:      v = QK_G_Z_VEL;
      KC_G_Z_OFS:      v = QK_G_Z_OFS;
      KC_M_TILT:       v = QK_M_TILT;
      KC_M_YAW:        v = QK_M_YAW;
      KC_M_THRUST:     v = QK_M_THRUST;
      default:         v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] field_q(logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e << IN_SHIFT;
  endfunction

  function automatic logic [63:0] const_q(logic [63:0] c);
    return (c << K_SHL) >> K_SHR;
  endfunction

  function automatic logic [15:0] motor_out(logic [63:0] v);
    logic [63:0] ip;
    ip = v >> FRAC_BITS;
    if (v[63]) begin
      return '0;
    end
    if (|ip[63:16]) begin
      return 16'hFFFF;
    end
    return ip[15:0];
  endfunction

  function automatic instr_t mk(op_e op, logic [4:0] arg);
    instr_t i;
    i.op  = op;
    i.arg = arg;
    return i;
  endfunction

  localparam int UC_LEN = 189;

  // Accumulator program for one control tick.
  localparam instr_t UCODE [UC_LEN] = '{
    // Rates in rad/s, acceleration in m/s^2.
    mk(OP_LD, R_GX), mk(OP_MUL, KC_DEG2RAD), mk(OP_ST, R_RR),
    mk(OP_LD, R_GY), mk(OP_MUL, KC_DEG2RAD), mk(OP_ST, R_PR),
    mk(OP_LD, R_GZ), mk(OP_MUL, KC_DEG2RAD), mk(OP_ST, R_YR),
    mk(OP_LD, R_AZ), mk(OP_MUL, KC_G), mk(OP_ST, R_AZ),
    // Torque estimates and prior rates.
    mk(OP_LD, R_RR), mk(OP_SUB, R_P0), mk(OP_MUL, KC_JX_DT), mk(OP_ST, R_TQR),
    mk(OP_LD, R_PR), mk(OP_SUB, R_P1), mk(OP_MUL, KC_JY_DT), mk(OP_ST, R_TQP),
    mk(OP_LD, R_RR), mk(OP_ST, R_P0), mk(OP_LD, R_PR), mk(OP_ST, R_P1),
    // Innovations.
    mk(OP_LD, R_S6), mk(OP_MUL, KC_FLOW_Z), mk(OP_ST, R_T), mk(OP_LD, R_PR),
    mk(OP_MUL, KC_FLOW), mk(OP_RSUB, R_T), mk(OP_SUB, R_FX), mk(OP_ST, R_EX),
    mk(OP_LD, R_S7), mk(OP_MUL, KC_FLOW_Z), mk(OP_ST, R_T), mk(OP_LD, R_RR),
    mk(OP_MUL, KC_FLOW), mk(OP_RSUB, R_T), mk(OP_SUB, R_FY), mk(OP_ST, R_EY),
    mk(OP_LD, R_S2), mk(OP_SUB, R_RNG), mk(OP_ST, R_EZ),
    // Observer update in state order.
    mk(OP_LD, R_S6), mk(OP_MUL, KC_DT), mk(OP_ADD, R_S0), mk(OP_ST, R_S0),
    mk(OP_LD, R_S7), mk(OP_MUL, KC_DT), mk(OP_ADD, R_S1), mk(OP_ST, R_S1),
    mk(OP_LD, R_EZ), mk(OP_MUL, KC_L_RANGE_Z), mk(OP_RSUB, R_S8), mk(OP_MUL, KC_DT),
    mk(OP_ADD, R_S2), mk(OP_ST, R_S2),
    mk(OP_LD, R_YR), mk(OP_MUL, KC_DT), mk(OP_ADD, R_S3), mk(OP_ST, R_S3),
    mk(OP_LD, R_EX), mk(OP_MUL, KC_L_FLOW_PITCH), mk(OP_RSUB, R_PR), mk(OP_MUL, KC_DT),
    mk(OP_ADD, R_S4), mk(OP_ST, R_S4),
    mk(OP_LD, R_EY), mk(OP_MUL, KC_L_FLOW_ROLL), mk(OP_ADD, R_RR), mk(OP_MUL, KC_DT),
    mk(OP_ADD, R_S5), mk(OP_ST, R_S5),
    mk(OP_LD, R_S4), mk(OP_MUL, KC_G), mk(OP_ST, R_T), mk(OP_LD, R_EX),
    mk(OP_MUL, KC_L_FLOW_VX), mk(OP_RSUB, R_T), mk(OP_MUL, KC_DT), mk(OP_ADD, R_S6),
    mk(OP_ST, R_S6),
    mk(OP_LD, R_S5), mk(OP_MUL, KC_G), mk(OP_NEG, R_S0), mk(OP_ST, R_T),
    mk(OP_LD, R_EY), mk(OP_MUL, KC_L_FLOW_VY), mk(OP_RSUB, R_T), mk(OP_MUL, KC_DT),
    mk(OP_ADD, R_S7), mk(OP_ST, R_S7),
    mk(OP_LDK, KC_G), mk(OP_RSUB, R_AZ), mk(OP_ST, R_T), mk(OP_LD, R_EZ),
    mk(OP_MUL, KC_L_RANGE_VZ), mk(OP_RSUB, R_T), mk(OP_MUL, KC_DT), mk(OP_ADD, R_S8),
    mk(OP_ST, R_S8),
    // Roll command.
    mk(OP_LD, R_S1), mk(OP_SUB, R_DY), mk(OP_MUL, KC_G_POS_XY), mk(OP_ST, R_T),
    mk(OP_LD, R_S5), mk(OP_MUL, KC_G_ROLL_ANG), mk(OP_RSUB, R_T), mk(OP_ST, R_T),
    mk(OP_LD, R_S7), mk(OP_MUL, KC_G_ROLL_VEL), mk(OP_ADD, R_T), mk(OP_ST, R_T),
    mk(OP_LD, R_RR), mk(OP_MUL, KC_G_ROLL_RATE), mk(OP_RSUB, R_T), mk(OP_ST, R_T),
    mk(OP_LD, R_TQR), mk(OP_MUL, KC_G_ROLL_TQ), mk(OP_RSUB, R_T), mk(OP_MUL, KC_M_TILT),
    mk(OP_ST, R_AX),
    // Pitch command.
    mk(OP_LD, R_S0), mk(OP_SUB, R_DX), mk(OP_MUL, KC_G_POS_XY), mk(OP_NEG, R_S0),
    mk(OP_ST, R_T),
    mk(OP_LD, R_S4), mk(OP_MUL, KC_G_PITCH_ANG), mk(OP_RSUB, R_T), mk(OP_ST, R_T),
    mk(OP_LD, R_S6), mk(OP_MUL, KC_G_PITCH_VEL), mk(OP_RSUB, R_T), mk(OP_ST, R_T),
    mk(OP_LD, R_PR), mk(OP_MUL, KC_G_PITCH_RATE), mk(OP_RSUB, R_T), mk(OP_ST, R_T),
    mk(OP_LD, R_TQP), mk(OP_MUL, KC_G_PITCH_TQ), mk(OP_RSUB, R_T), mk(OP_MUL, KC_M_TILT),
    mk(OP_ST, R_AY),
    // Yaw command.
    mk(OP_LD, R_S3), mk(OP_MUL, KC_G_YAW_ANG), mk(OP_NEG, R_S0), mk(OP_ST, R_T),
    mk(OP_LD, R_YR), mk(OP_MUL, KC_G_YAW_RATE), mk(OP_RSUB, R_T), mk(OP_MUL, KC_M_YAW),
    mk(OP_ST, R_BZ),
    // Thrust.
    mk(OP_LD, R_S2), mk(OP_SUB, R_DZ), mk(OP_MUL, KC_G_Z_POS), mk(OP_NEG, R_S0),
    mk(OP_ST, R_T),
    mk(OP_LD, R_S8), mk(OP_MUL, KC_G_Z_VEL), mk(OP_RSUB, R_T), mk(OP_ST, R_T),
    mk(OP_LDK, KC_G_Z_OFS), mk(OP_ADD, R_T), mk(OP_MUL, KC_M_THRUST), mk(OP_ST, R_CF),
    // Mixer.
    mk(OP_LD, R_AX), mk(OP_NEG, R_S0), mk(OP_SUB, R_AY), mk(OP_SUB, R_BZ),
    mk(OP_ADD, R_CF), mk(OP_MOT, 5'd0),
    mk(OP_LD, R_AX), mk(OP_NEG, R_S0), mk(OP_ADD, R_AY), mk(OP_ADD, R_BZ),
    mk(OP_ADD, R_CF), mk(OP_MOT, 5'd1),
    mk(OP_LD, R_AX), mk(OP_ADD, R_AY), mk(OP_SUB, R_BZ), mk(OP_ADD, R_CF),
    mk(OP_MOT, 5'd2),
    mk(OP_LD, R_AX), mk(OP_SUB, R_AY), mk(OP_ADD, R_BZ), mk(OP_ADD, R_CF),
    mk(OP_MOT, 5'd3),
    mk(OP_END, 5'd0)
  };

endpackage

`default_nettype wire

// ===== design/quadrotor_observer_state_feedback.sv =====
// Quadrotor observer and state-feedback controller, one control tick per transfer.
// The input channel (in_valid_i / in_ready_o) carries gyro rates, vertical
// acceleration, optical flow, range, a position target and the hold and clear
// flags. The output channel (out_valid_o / out_ready_i) returns the four motor
// commands for that tick. In-flight work is one tick at a time: in_ready_o is
// high only while the sequencer is idle.
// Each tick runs a fixed accumulator program of 188 steps and a closing step.
// Each of the 45 constant multiplications goes through the single 32x32
// multiplier, which works through four partial products and a saturation step.
// in_ready_o rises in the same cycle as out_valid_o, so a new tick is taken
// only once the block is through with the last one.
// The result sits in an output register, so a stalled receiver does not block
// the next input transfer; only the following result waits until the pending
// one has been taken.
// Reset clears the nine estimates, the two prior rates and all control state.
`default_nettype none
`include "quadrotor_observer_state_feedback_macros.svh"

module quadrotor_observer_state_feedback (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] gyro_x_i,
  input  logic signed [31:0] gyro_y_i,
  input  logic signed [31:0] gyro_z_i,
  input  logic signed [31:0] accel_z_i,
  input  logic signed [31:0] flow_dx_i,
  input  logic signed [31:0] flow_dy_i,
  input  logic signed [31:0] range_m_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic               hold_motors_i,
  input  logic               clear_estimate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        motor_1_o,
  output logic [15:0]        motor_2_o,
  output logic [15:0]        motor_3_o,
  output logic [15:0]        motor_4_o
);
  import qosf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_MUL, S_MFIN, S_DONE} state_e;

  state_e       state_q;
  logic [7:0]   pc_q;
  logic [63:0]  acc_q;
  logic [63:0]  rf_q [RF_DEPTH];
  logic         hold_q;
  logic [15:0]  mot_q [4];
  logic [15:0]  res_q [4];
  logic         out_valid_q;

  // Shared multiplier state: magnitude of the operand, constant, sign and sum.
  logic [63:0]  ma_q;
  logic [63:0]  mc_q;
  logic         mneg_q;
  logic [1:0]   mstep_q;
  logic [127:0] prod_q;

  instr_t       ins;
  logic [63:0]  rd;
  logic [63:0]  alu_res;
  logic [63:0]  acc_abs;
  logic [31:0]  a_part;
  logic [31:0]  c_part;
  logic [63:0]  pp;
  logic [1:0]   pp_pos;
  logic [127:0] pp_ext;
  logic [63:0]  mul_lim;
  logic [63:0]  mul_mag;
  logic [63:0]  mul_res;

  assign ins = UCODE[pc_q];
  assign rd  = rf_q[ins.arg];

  // Combinational accumulator operations; every sum saturates to 64 bits.
  always_comb begin
    unique case (ins.op)
      OP_LD:   alu_res = rd;
      OP_LDK:  alu_res = const_q(kconst(kc_e'(ins.arg)));
      OP_ADD:  alu_res = sat_add(acc_q, rd);
      OP_SUB:  alu_res = sat_sub(acc_q, rd);
      OP_RSUB: alu_res = sat_sub(rd, acc_q);
      OP_NEG:  alu_res = sat_sub(64'd0, acc_q);
      default: alu_res = acc_q;
    endcase
  end

  assign acc_abs = acc_q[63] ? (~acc_q + 64'd1) : acc_q;

  // One 32x32 partial product per cycle, weighted by its position.
  assign a_part = mstep_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign c_part = mstep_q[0] ? mc_q[63:32] : mc_q[31:0];
  assign pp     = a_part * c_part;
  assign pp_pos = 2'({1'b0, mstep_q[1]} + {1'b0, mstep_q[0]});
  assign pp_ext = {64'd0, pp} << {pp_pos, 5'd0};

  // The product is taken at 2^-32 and truncated toward zero, then saturated.
  assign mul_lim = mneg_q ? S64_MIN : S64_MAX;
  assign mul_mag = prod_q[95:32];
  always_comb begin
    if ((|prod_q[127:96]) || (mul_mag > mul_lim)) begin
      mul_res = mneg_q ? S64_MIN : S64_MAX;
    end else begin
      mul_res = mneg_q ? (~mul_mag + 64'd1) : mul_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      acc_q       <= '0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ma_q        <= '0;
      mc_q        <= '0;
      mneg_q      <= 1'b0;
      mstep_q     <= '0;
      prod_q      <= '0;
      for (int i = 0; i < RF_DEPTH; i++) begin
        rf_q[i] <= '0;
      end
      for (int j = 0; j < 4; j++) begin
        mot_q[j] <= '0;
        res_q[j] <= '0;
      end
    end else begin
      // In the done state the new result replaces a taken one directly.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            rf_q[R_GX]  <= field_q(gyro_x_i);
            rf_q[R_GY]  <= field_q(gyro_y_i);
            rf_q[R_GZ]  <= field_q(gyro_z_i);
            rf_q[R_AZ]  <= field_q(accel_z_i);
            rf_q[R_FX]  <= field_q(flow_dx_i);
            rf_q[R_FY]  <= field_q(flow_dy_i);
            rf_q[R_RNG] <= field_q(range_m_i);
            rf_q[R_DX]  <= field_q(target_x_i);
            rf_q[R_DY]  <= field_q(target_y_i);
            rf_q[R_DZ]  <= field_q(target_z_i);
            // Clearing touches the estimates only; prior rates are kept.
            if (clear_estimate_i) begin
              for (int i = 0; i < 9; i++) begin
                rf_q[i] <= '0;
              end
            end
            hold_q  <= hold_motors_i;
            pc_q    <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          unique case (ins.op)
            OP_MUL: begin
              ma_q    <= acc_abs;
              mneg_q  <= acc_q[63];
              mc_q    <= kconst(kc_e'(ins.arg));
              prod_q  <= '0;
              mstep_q <= '0;
              state_q <= S_MUL;
            end
            OP_ST: begin
              rf_q[ins.arg] <= acc_q;
              pc_q          <= pc_q + 8'd1;
            end
            OP_MOT: begin
              mot_q[ins.arg[1:0]] <= motor_out(acc_q);
              pc_q                <= pc_q + 8'd1;
            end
            OP_END: begin
              state_q <= S_DONE;
            end
            default: begin
              acc_q <= alu_res;
              pc_q  <= pc_q + 8'd1;
            end
          endcase
        end
        S_MUL: begin
          prod_q  <= prod_q + pp_ext;
          mstep_q <= mstep_q + 2'd1;
          if (mstep_q == 2'd3) begin
            state_q <= S_MFIN;
          end
        end
        S_MFIN: begin
          acc_q   <= mul_res;
          pc_q    <= pc_q + 8'd1;
          state_q <= S_RUN;
        end
        S_DONE: begin
          // Wait here only if the previous result has not been taken yet.
          if (!out_valid_q || out_ready_i) begin
            for (int j = 0; j < 4; j++) begin
              res_q[j] <= hold_q ? 16'd0 : mot_q[j];
            end
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign motor_1_o   = res_q[0];
  assign motor_2_o   = res_q[1];
  assign motor_3_o   = res_q[2];
  assign motor_4_o   = res_q[3];

  `QOSF_ASSERT_NEXT(a_run_after_accept, in_valid_i && in_ready_o, state_q == S_RUN)
  `QOSF_ASSERT_IMP(a_mul_four_steps, state_q == S_MFIN,
                   $past(state_q) == S_MUL && $past(mstep_q) == 2'd3)
  `QOSF_ASSERT_IMP(a_pc_in_range, state_q == S_RUN, pc_q < UC_LEN)
  `QOSF_ASSERT_IMP(a_result_from_done, $rose(out_valid_o), $past(state_q) == S_DONE)

endmodule

`default_nettype wire

// ===== test/quadrotor_observer_state_feedback_test.sv =====
`default_nettype none

module quadrotor_observer_state_feedback_test;
  import qosf_pkg::*;

  typedef logic signed [63:0] q_t;

  // One control tick as it crosses the input channel.
  typedef struct {
    logic signed [31:0] gx, gy, gz, az, fx, fy, rng, tx, ty, tz;
    logic               hold, clr;
  } tick_t;

  typedef struct {
    logic [15:0] m1, m2, m3, m4;
  } motors_t;

  localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

  // The scoreboard keeps its own copy of the observer state and predicts the
  // motor commands of every tick that is transferred into the block.
  class motor_scoreboard;
    q_t      est[9];
    q_t      prev_rate[2];
    motors_t awaited[$];
    int      errors, ticks, results, holds, clears;

    function new();
      foreach (est[i]) est[i] = 0;
      prev_rate[0] = 0;
      prev_rate[1] = 0;
    endfunction

    function q_t clip(logic signed [64:0] s);
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
    endfunction

    function q_t add(q_t a, q_t b);
      return clip({a[63], a} + {b[63], b});
    endfunction

    function q_t sub(q_t a, q_t b);
      return clip({a[63], a} - {b[63], b});
    endfunction

    // Product with a positive Q32.32 constant, truncated toward zero.
    function q_t mulk(q_t a, logic [63:0] k);
      logic [63:0]  mag;
      logic [127:0] p;
      logic [127:0] lim;
      mag = a[63] ? -a : a;
      p   = ({64'd0, mag} * {64'd0, k}) >> 32;
      lim = a[63] ? (128'd1 << 63) : ((128'd1 << 63) - 1);
      if (p > lim) return a[63] ? Q_MIN : Q_MAX;
      return a[63] ? -q_t'(p[63:0]) : q_t'(p[63:0]);
    endfunction

    function q_t widen(logic signed [31:0] v);
      q_t e;
      e = v;
      return e <<< (FRAC_BITS - 16);
    endfunction

    function q_t kq(logic [63:0] c);
      if (FRAC_BITS >= 32) return q_t'(c << (FRAC_BITS - 32));
      return q_t'(c) >>> (32 - FRAC_BITS);
    endfunction

    function logic [15:0] to_motor(q_t v);
      logic [63:0] ip;
      if (v < 0) return 16'd0;
      ip = 64'(v) >> FRAC_BITS;
      return (ip > 64'd65535) ? 16'hFFFF : ip[15:0];
    endfunction

    function void note_tick(tick_t t);
      q_t rr, pr, yr, acc, fx, fy, rng, dx, dy, dz, tqr, tqp, ex, ey, ez;
      q_t cr, cp, cy, th, ax, ay, bz, cf;
      motors_t m;
      ticks++;
      rr  = mulk(widen(t.gx), QK_DEG2RAD);
      pr  = mulk(widen(t.gy), QK_DEG2RAD);
      yr  = mulk(widen(t.gz), QK_DEG2RAD);
      acc = mulk(widen(t.az), QK_G);
      fx = widen(t.fx); fy = widen(t.fy); rng = widen(t.rng);
      dx = widen(t.tx); dy = widen(t.ty); dz = widen(t.tz);
      tqr = mulk(sub(rr, prev_rate[0]), QK_JX_DT);
      tqp = mulk(sub(pr, prev_rate[1]), QK_JY_DT);
      prev_rate[0] = rr;
      prev_rate[1] = pr;
      if (t.clr) begin
        clears++;
        foreach (est[i]) est[i] = 0;
      end
      ex = sub(sub(mulk(est[6], QK_FLOW_Z), mulk(pr, QK_FLOW)), fx);
      ey = sub(sub(mulk(est[7], QK_FLOW_Z), mulk(rr, QK_FLOW)), fy);
      ez = sub(est[2], rng);
      // Integration order matters: velocities see the angles of this tick.
      est[0] = add(est[0], mulk(est[6], QK_DT));
      est[1] = add(est[1], mulk(est[7], QK_DT));
      est[2] = add(est[2], mulk(sub(est[8], mulk(ez, QK_L_RANGE_Z)), QK_DT));
      est[3] = add(est[3], mulk(yr, QK_DT));
      est[4] = add(est[4], mulk(sub(pr, mulk(ex, QK_L_FLOW_PITCH)), QK_DT));
      est[5] = add(est[5], mulk(add(rr, mulk(ey, QK_L_FLOW_ROLL)), QK_DT));
      est[6] = add(est[6], mulk(sub(mulk(est[4], QK_G), mulk(ex, QK_L_FLOW_VX)), QK_DT));
      est[7] = add(est[7], mulk(sub(sub(0, mulk(est[5], QK_G)),
                                    mulk(ey, QK_L_FLOW_VY)), QK_DT));
      est[8] = add(est[8], mulk(sub(sub(acc, kq(QK_G)), mulk(ez, QK_L_RANGE_VZ)), QK_DT));
      if (t.hold) begin
        holds++;
        m = '{16'd0, 16'd0, 16'd0, 16'd0};
        awaited.push_back(m);
        return;
      end
      cr = mulk(sub(est[1], dy), QK_G_POS_XY);
      cr = sub(cr, mulk(est[5], QK_G_ROLL_ANG));
      cr = add(cr, mulk(est[7], QK_G_ROLL_VEL));
      cr = sub(cr, mulk(rr, QK_G_ROLL_RATE));
      cr = sub(cr, mulk(tqr, QK_G_ROLL_TQ));
      cp = sub(0, mulk(sub(est[0], dx), QK_G_POS_XY));
      cp = sub(cp, mulk(est[4], QK_G_PITCH_ANG));
      cp = sub(cp, mulk(est[6], QK_G_PITCH_VEL));
      cp = sub(cp, mulk(pr, QK_G_PITCH_RATE));
      cp = sub(cp, mulk(tqp, QK_G_PITCH_TQ));
      cy = sub(sub(0, mulk(est[3], QK_G_YAW_ANG)), mulk(yr, QK_G_YAW_RATE));
      th = sub(0, mulk(sub(est[2], dz), QK_G_Z_POS));
      th = sub(th, mulk(est[8], QK_G_Z_VEL));
      th = add(th, kq(QK_G_Z_OFS));
      ax = mulk(cr, QK_M_TILT);
      ay = mulk(cp, QK_M_TILT);
      bz = mulk(cy, QK_M_YAW);
      cf = mulk(th, QK_M_THRUST);
      m.m1 = to_motor(add(sub(sub(sub(0, ax), ay), bz), cf));
      m.m2 = to_motor(add(add(add(sub(0, ax), ay), bz), cf));
      m.m3 = to_motor(add(sub(add(ax, ay), bz), cf));
      m.m4 = to_motor(add(add(sub(ax, ay), bz), cf));
      awaited.push_back(m);
    endfunction

    function void check_motors(motors_t got);
      motors_t exp_m;
      results++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h %h %h %h", $time,
                 got.m1, got.m2, got.m3, got.m4);
        return;
      end
      exp_m = awaited.pop_front();
      if (exp_m.m1 !== got.m1) begin
        errors++;
        $display("%0t: motor_1 expected %h actual %h", $time, exp_m.m1, got.m1);
      end
      if (exp_m.m2 !== got.m2) begin
        errors++;
        $display("%0t: motor_2 expected %h actual %h", $time, exp_m.m2, got.m2);
      end
      if (exp_m.m3 !== got.m3) begin
        errors++;
        $display("%0t: motor_3 expected %h actual %h", $time, exp_m.m3, got.m3);
      end
      if (exp_m.m4 !== got.m4) begin
        errors++;
        $display("%0t: motor_4 expected %h actual %h", $time, exp_m.m4, got.m4);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] gyro_x_i = '0, gyro_y_i = '0, gyro_z_i = '0, accel_z_i = '0;
  logic signed [31:0] flow_dx_i = '0, flow_dy_i = '0, range_m_i = '0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic hold_motors_i = 1'b0, clear_estimate_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] motor_1_o, motor_2_o, motor_3_o, motor_4_o;

  motor_scoreboard board = new();

  // Idling modes: 0 none, 1 sender, 2 receiver, 3 both.
  int idle_mode = 0;
  int holdoff_cycles = 0;

  always #10 clk_i = ~clk_i;

  quadrotor_observer_state_feedback DUT (.*);

  // Transfers are observed on the edge itself; all drivers use nonblocking
  // assignments, so the values seen here are those of the closing cycle.
  always @(posedge clk_i) begin
    tick_t   t;
    motors_t m;
    if (rst_ni && in_valid_i && in_ready_o) begin
      t = '{gyro_x_i, gyro_y_i, gyro_z_i, accel_z_i, flow_dx_i, flow_dy_i,
            range_m_i, target_x_i, target_y_i, target_z_i, hold_motors_i,
            clear_estimate_i};
      board.note_tick(t);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      m = '{motor_1_o, motor_2_o, motor_3_o, motor_4_o};
      board.check_motors(m);
    end
  end

  // Receiver: stalls at random in the receiver modes, and during a long
  // hold-off it refuses every result so that the block backs up.
  initial begin
    forever begin
      @(posedge clk_i);
      if (holdoff_cycles > 0) begin
        holdoff_cycles--;
        out_ready_i <= 1'b0;
      end else if (idle_mode >= 2) begin
        out_ready_i <= ($urandom_range(99) >= (idle_mode == 2 ? 61 : 12));
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one tick and keep it steady until the transfer happens.
  task automatic send_tick(tick_t t);
    in_valid_i       <= 1'b1;
    gyro_x_i         <= t.gx;
    gyro_y_i         <= t.gy;
    gyro_z_i         <= t.gz;
    accel_z_i        <= t.az;
    flow_dx_i        <= t.fx;
    flow_dy_i        <= t.fy;
    range_m_i        <= t.rng;
    target_x_i       <= t.tx;
    target_y_i       <= t.ty;
    target_z_i       <= t.tz;
    hold_motors_i    <= t.hold;
    clear_estimate_i <= t.clr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sender gaps: mostly short, now and then long enough to land anywhere
  // inside the block's work on a tick.
  task automatic sender_gap();
    int n;
    if (!(idle_mode == 1 || idle_mode == 3)) return;
    if ($urandom_range(99) >= (idle_mode == 1 ? 61 : 12)) return;
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 450) : $urandom_range(1, 4);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick(int lo, int hi);
    // Realistic values in Q16.16 most of the time, raw 32-bit words otherwise.
    if ($urandom_range(9) == 0) return $urandom;
    return ($urandom_range(hi - lo) + lo) * 32'sd65536 + $urandom_range(65535);
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.gx   = pick(-500, 499);
    t.gy   = pick(-500, 499);
    t.gz   = pick(-500, 499);
    t.az   = pick(0, 1);
    t.fx   = pick(-20, 19);
    t.fy   = pick(-20, 19);
    t.rng  = pick(0, 3);
    t.tx   = pick(-2, 1);
    t.ty   = pick(-2, 1);
    t.tz   = pick(0, 1);
    t.hold = ($urandom_range(99) < 10);
    t.clr  = ($urandom_range(99) < 4);
    return t;
  endfunction

  function automatic tick_t flat_tick(logic signed [31:0] v, logic h, logic c);
    tick_t t;
    t = '{v, v, v, v, v, v, v, v, v, v, h, c};
    return t;
  endfunction

  initial begin
    tick_t t;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks: quiet hover, field extremes, hold and clear alone and
    // together, and saturating swings from one extreme to the other.
    send_tick(flat_tick(32'sd0, 1'b0, 1'b0));
    send_tick(flat_tick(32'sh7FFF_FFFF, 1'b0, 1'b0));
    send_tick(flat_tick(32'sh8000_0000, 1'b0, 1'b0));
    send_tick(flat_tick(32'sh7FFF_FFFF, 1'b0, 1'b0));
    send_tick(flat_tick(32'sh8000_0000, 1'b1, 1'b0));
    send_tick(flat_tick(32'sd0, 1'b0, 1'b1));
    send_tick(flat_tick(32'sh7FFF_FFFF, 1'b1, 1'b1));
    send_tick(flat_tick(-32'sd1, 1'b0, 1'b1));
    send_tick(flat_tick(32'sd1, 1'b0, 1'b0));
    t = flat_tick(32'sd0, 1'b0, 1'b1);
    t.az = 32'sd65536;
    t.tz = 32'sd65536;
    t.rng = 32'sd32768;
    send_tick(t);
    repeat (6) begin
      t.gx = t.gx + 32'sd655360;
      t.gy = t.gy - 32'sd327680;
      t.fx = 32'sd196608;
      t.clr = 1'b0;
      send_tick(t);
    end
    t = flat_tick(32'sh5555_5555, 1'b0, 1'b0);
    send_tick(t);
    t = flat_tick(32'shAAAA_AAAA, 1'b0, 1'b0);
    send_tick(t);
    send_tick(flat_tick(32'sd0, 1'b0, 1'b1));

    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = phase;
      for (int i = 0; i < 355; i++) begin
        send_tick(random_tick());
        sender_gap();
        // Once, hold the receiver off for a long while with ticks still offered.
        if (phase == 1 && i == 100) holdoff_cycles = 3000;
        // Once, let everything drain before carrying on.
        if (phase == 2 && i == 150) begin
          in_valid_i <= 1'b0;
          while (board.awaited.size() != 0) @(posedge clk_i);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);

    $display("Ran %0d ticks, %0d with motors held and %0d with the estimate cleared,",
             board.ticks, board.holds, board.clears);
    $display("through four idling patterns and a long receiver stall; %0d results checked.",
             board.results);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/qosf_pkg.sv
design/quadrotor_observer_state_feedback.sv
test/quadrotor_observer_state_feedback_test.sv
